// ----- sv/lrc_pkg.sv -----
// Shared constants and codes for the keyed result cache.
`timescale 1ns / 1ps
package lrc_pkg;

  localparam int unsigned EntriesDefault = 512;
  localparam int unsigned PlanesDefault  = 3;

  localparam int unsigned CapW     = 10;
  localparam int unsigned CapReset = 500;

  localparam int unsigned KeyHighW = 64;
  localparam int unsigned KeyMidW  = 64;
  localparam int unsigned KeyLowW  = 32;
  localparam int unsigned KeyW     = KeyHighW + KeyMidW + KeyLowW;
  localparam int unsigned SizeW    = 64;
  localparam int unsigned AlignW   = 64;
  localparam int unsigned TypeW    = 32;
  localparam int unsigned RecW     = SizeW + AlignW + TypeW + 2;

  // Operation codes
  localparam logic [1:0] OpLookupAll   = 2'd0;
  localparam logic [1:0] OpLookupPlane = 2'd1;
  localparam logic [1:0] OpStore       = 2'd2;
  localparam logic [1:0] OpUnused      = 2'd3;

  // Store status codes
  localparam logic [1:0] StNone  = 2'd0;
  localparam logic [1:0] StFree  = 2'd1;
  localparam logic [1:0] StEvict = 2'd2;
  localparam logic [1:0] StSkip  = 2'd3;

endpackage

// ----- sv/lru_keyed_result_cache_core.sv -----
// Fully associative, least recently used result cache keyed by a 160-bit digest.
`timescale 1ns / 1ps
// Fully associative cache of plane records keyed by a 160-bit digest, with least recently
// used replacement. One request is taken at a time: the block drops in_stall_o only when
// idle. A lookup or a plane-0 store scans every tag and recency rank through the read
// ports of the tag and rank memories, then a hit or a store of a new key makes a second
// read-modify-write pass over the recency ranks. A store then writes the tag and PLANES
// record rows, one per cycle. Each result is read from the record memory and then loaded
// into the output register once that register is free of a stalled result. After reset,
// a clearing pass sweeps the valid bits and ranks of every entry before the first
// request is taken; capacity writes are taken at any time (cfg_ready_o is always high).
module lru_keyed_result_cache_core #(
  parameter int unsigned ENTRIES = lrc_pkg::EntriesDefault,
  parameter int unsigned PLANES  = lrc_pkg::PlanesDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // capacity register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lrc_pkg::CapW-1:0]    cfg_data_i,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [lrc_pkg::KeyHighW-1:0] key_high_i,
  input  logic [lrc_pkg::KeyMidW-1:0] key_mid_i,
  input  logic [lrc_pkg::KeyLowW-1:0] key_low_i,
  input  logic [1:0]                  plane_i,
  input  logic [1:0]                  plane_count_i,
  input  logic [lrc_pkg::SizeW-1:0]   mem_size_i,
  input  logic [lrc_pkg::AlignW-1:0]  mem_alignment_i,
  input  logic [lrc_pkg::TypeW-1:0]   type_bits_i,
  input  logic                        prefers_dedicated_i,
  input  logic                        requires_dedicated_i,
  input  logic                        run_last_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        hit_o,
  output logic [1:0]                  out_plane_o,
  output logic [lrc_pkg::SizeW-1:0]   out_size_o,
  output logic [lrc_pkg::AlignW-1:0]  out_alignment_o,
  output logic [lrc_pkg::TypeW-1:0]   out_type_bits_o,
  output logic                        out_prefers_o,
  output logic                        out_requires_o,
  output logic [1:0]                  store_status_o,
  output logic                        last_o
);
  import lrc_pkg::*;

  localparam int unsigned IW   = $clog2(ENTRIES);
  localparam int unsigned RAW  = $clog2(ENTRIES * PLANES);
  localparam int unsigned PHW  = $clog2(PLANES + 1);
  localparam int unsigned MW   = 1 + IW + PHW;
  localparam int unsigned UW   = IW + 1;
  localparam int unsigned LimW = (UW > CapW) ? UW : CapW;

  // sequencer states
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_UPD    = 4'd4;
  localparam logic [3:0] S_WR     = 4'd5;
  localparam logic [3:0] S_CRD    = 4'd6;
  localparam logic [3:0] S_CCHK   = 4'd7;
  localparam logic [3:0] S_RRD    = 4'd8;
  localparam logic [3:0] S_EMIT   = 4'd9;

  // ---------------------------------------------------------------- memories
  logic [KeyW-1:0] tag_mem [ENTRIES];
  logic [MW-1:0]   meta_mem [ENTRIES];   // {valid, rank, planes held}
  logic [RecW-1:0] rec_mem [ENTRIES*PLANES];

  logic            tag_we;
  logic [IW-1:0]   tag_wa, tag_ra;
  logic [KeyW-1:0] tag_wd, tag_rd_q;
  logic            meta_we;
  logic [IW-1:0]   meta_wa, meta_ra;
  logic [MW-1:0]   meta_wd, meta_rd_q;
  logic            rec_we;
  logic [RAW-1:0]  rec_wa, rec_ra;
  logic [RecW-1:0] rec_wd, rec_rd_q;

  always_ff @(posedge clk_i) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    tag_rd_q <= tag_mem[tag_ra];
  end

  always_ff @(posedge clk_i) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    meta_rd_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_rd_q <= rec_mem[rec_ra];
  end

  // ---------------------------------------------------------------- registers
  logic [3:0]       state_q, state_d;
  logic [UW-1:0]    cnt_q, cnt_d;
  logic             pv_q, pv_d;
  logic [IW-1:0]    pidx_q, pidx_d;

  logic [1:0]       op_q, op_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [1:0]       plane_q, plane_d;
  logic [PHW-1:0]   pc_q, pc_d;
  logic [RecW-1:0]  rec_in_q, rec_in_d;
  logic             rlast_q, rlast_d;

  logic             match_v_q, match_v_d, free_v_q, free_v_d, lru_v_q, lru_v_d;
  logic [IW-1:0]    match_idx_q, match_idx_d, free_idx_q, free_idx_d, lru_idx_q, lru_idx_d;
  logic [IW-1:0]    match_rank_q, match_rank_d, lru_rank_q, lru_rank_d;
  logic [PHW-1:0]   match_pl_q, match_pl_d;

  logic [IW-1:0]    sel_q, sel_d;
  logic [IW-1:0]    rref_q, rref_d;
  logic             mode_new_q, mode_new_d;
  logic [PHW-1:0]   planes_new_q, planes_new_d;
  logic             hit_q, hit_d;
  logic [1:0]       status_q, status_d;

  logic [UW-1:0]    used_q, used_d;
  logic [IW-1:0]    pending_q, pending_d;
  logic             skip_q, skip_d;
  logic [CapW-1:0]  cap_q;

  logic [1:0]       ep_q, ep_d;
  logic [2:0]       rem_q, rem_d;
  logic             emit_rec_q, emit_rec_d;
  logic             rec_ok_q, rec_ok_d;

  logic             out_valid_q, out_valid_d;
  logic             out_hit_q, out_hit_d;
  logic [1:0]       out_plane_q, out_plane_d;
  logic [RecW-1:0]  out_rec_q, out_rec_d;
  logic [1:0]       out_status_q, out_status_d;
  logic             out_last_q, out_last_d;

  // ---------------------------------------------------------------- helpers
  logic [PHW-1:0] pc_clamped;
  logic [LimW-1:0] lim;
  logic           meta_valid;
  logic [IW-1:0]  meta_rank;
  logic [PHW-1:0] meta_planes;
  logic           out_free;
  logic           rec_ok;

  assign meta_valid  = meta_rd_q[MW-1];
  assign meta_rank   = meta_rd_q[IW+PHW-1:PHW];
  assign meta_planes = meta_rd_q[PHW-1:0];
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if (plane_count_i == 2'd0) begin
      pc_clamped = PHW'(1);
    end else if (32'(plane_count_i) > PLANES) begin
      pc_clamped = PHW'(PLANES);
    end else begin
      pc_clamped = PHW'(plane_count_i);
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      lim = LimW'(1);
    end else if (32'(cap_q) > ENTRIES) begin
      lim = LimW'(ENTRIES);
    end else begin
      lim = LimW'(cap_q);
    end
  end

  assign rec_ok = emit_rec_q && (32'(ep_q) < PLANES) && (32'(ep_q) < 32'(planes_new_q));

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pv_d         = 1'b0;
    pidx_d       = pidx_q;
    op_d         = op_q;
    key_d        = key_q;
    plane_d      = plane_q;
    pc_d         = pc_q;
    rec_in_d     = rec_in_q;
    rlast_d      = rlast_q;
    match_v_d    = match_v_q;
    match_idx_d  = match_idx_q;
    match_rank_d = match_rank_q;
    match_pl_d   = match_pl_q;
    free_v_d     = free_v_q;
    free_idx_d   = free_idx_q;
    lru_v_d      = lru_v_q;
    lru_idx_d    = lru_idx_q;
    lru_rank_d   = lru_rank_q;
    sel_d        = sel_q;
    rref_d       = rref_q;
    mode_new_d   = mode_new_q;
    planes_new_d = planes_new_q;
    hit_d        = hit_q;
    status_d     = status_q;
    used_d       = used_q;
    pending_d    = pending_q;
    skip_d       = skip_q;
    ep_d         = ep_q;
    rem_d        = rem_q;
    emit_rec_d   = emit_rec_q;
    rec_ok_d     = rec_ok_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_hit_d    = out_hit_q;
    out_plane_d  = out_plane_q;
    out_rec_d    = out_rec_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    tag_we  = 1'b0;
    tag_wa  = sel_q;
    tag_wd  = key_q;
    tag_ra  = cnt_q[IW-1:0];
    meta_we = 1'b0;
    meta_wa = pidx_q;
    meta_wd = '0;
    meta_ra = cnt_q[IW-1:0];
    rec_we  = 1'b0;
    rec_wa  = '0;
    rec_wd  = '0;
    rec_ra  = '0;

    case (state_q)
      S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = cnt_q[IW-1:0];
        meta_wd = '0;
        if (cnt_q == UW'(ENTRIES - 1)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + UW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          op_d     = operation_i;
          key_d    = {key_high_i, key_mid_i, key_low_i};
          plane_d  = plane_i;
          pc_d     = pc_clamped;
          rec_in_d = {requires_dedicated_i, prefers_dedicated_i, type_bits_i,
                      mem_alignment_i, mem_size_i};
          rlast_d  = run_last_i;
          cnt_d    = '0;
          match_v_d = 1'b0;
          free_v_d  = 1'b0;
          lru_v_d   = 1'b0;
          if (operation_i == OpUnused) begin
            hit_d      = 1'b0;
            status_d   = StNone;
            ep_d       = 2'd0;
            rem_d      = 3'd1;
            emit_rec_d = 1'b0;
            state_d    = S_RRD;
          end else if (operation_i == OpStore && plane_i != 2'd0) begin
            state_d = S_CRD;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (cnt_q != UW'(ENTRIES)) begin
          pv_d   = 1'b1;
          pidx_d = cnt_q[IW-1:0];
          cnt_d  = cnt_q + UW'(1);
        end
        if (pv_q) begin
          if (meta_valid && tag_rd_q == key_q && !match_v_q) begin
            match_v_d    = 1'b1;
            match_idx_d  = pidx_q;
            match_rank_d = meta_rank;
            match_pl_d   = meta_planes;
          end
          if (!meta_valid && !free_v_q) begin
            free_v_d   = 1'b1;
            free_idx_d = pidx_q;
          end
          if (meta_valid && (!lru_v_q || meta_rank > lru_rank_q)) begin
            lru_v_d    = 1'b1;
            lru_idx_d  = pidx_q;
            lru_rank_d = meta_rank;
          end
        end
        if (cnt_q == UW'(ENTRIES) && !pv_q) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        cnt_d = '0;
        if (op_q != OpStore) begin
          if (!match_v_q) begin
            hit_d      = 1'b0;
            status_d   = StNone;
            ep_d       = 2'd0;
            rem_d      = 3'd1;
            emit_rec_d = 1'b0;
            state_d    = S_RRD;
          end else begin
            sel_d        = match_idx_q;
            rref_d       = match_rank_q;
            mode_new_d   = 1'b0;
            planes_new_d = match_pl_q;
            hit_d        = 1'b1;
            status_d     = StNone;
            state_d      = S_UPD;
          end
        end else if (match_v_q) begin
          // key already present: drop the rest of this run
          skip_d     = 1'b1;
          hit_d      = 1'b1;
          status_d   = StSkip;
          ep_d       = 2'd0;
          rem_d      = 3'd1;
          emit_rec_d = 1'b0;
          state_d    = S_RRD;
        end else begin
          hit_d        = 1'b0;
          planes_new_d = pc_q;
          state_d      = S_UPD;
          if (LimW'(used_q) < lim && free_v_q) begin
            sel_d      = free_idx_q;
            rref_d     = '0;
            mode_new_d = 1'b1;
            status_d   = StFree;
            used_d     = used_q + UW'(1);
          end else begin
            sel_d      = lru_v_q ? lru_idx_q : '0;
            rref_d     = lru_rank_q;
            mode_new_d = 1'b0;
            status_d   = StEvict;
          end
        end
      end

      S_UPD: begin
        if (cnt_q != UW'(ENTRIES)) begin
          pv_d   = 1'b1;
          pidx_d = cnt_q[IW-1:0];
          cnt_d  = cnt_q + UW'(1);
        end
        if (pv_q) begin
          meta_wa = pidx_q;
          if (pidx_q == sel_q) begin
            meta_we = 1'b1;
            meta_wd = {1'b1, IW'(0), planes_new_q};
          end else if (meta_valid && (mode_new_q || meta_rank < rref_q)) begin
            meta_we = 1'b1;
            meta_wd = {1'b1, meta_rank + IW'(1), meta_planes};
          end
        end
        if (cnt_q == UW'(ENTRIES) && !pv_q) begin
          cnt_d = '0;
          if (op_q == OpStore) begin
            state_d = S_WR;
          end else begin
            emit_rec_d = 1'b1;
            if (op_q == OpLookupAll) begin
              ep_d  = 2'd0;
              rem_d = 3'(planes_new_q);
            end else begin
              ep_d  = plane_q;
              rem_d = 3'd1;
            end
            state_d = S_RRD;
          end
        end
      end

      S_WR: begin
        // plane 0 takes the request's record, the other planes clear to zero
        rec_we = 1'b1;
        rec_wa = RAW'(sel_q) * RAW'(PLANES) + RAW'(cnt_q);
        rec_wd = (cnt_q == '0) ? rec_in_q : '0;
        tag_we = (cnt_q == '0);
        if (cnt_q == UW'(PLANES - 1)) begin
          pending_d  = sel_q;
          skip_d     = rlast_q;
          ep_d       = 2'd0;
          rem_d      = 3'd1;
          emit_rec_d = 1'b0;
          state_d    = S_RRD;
        end else begin
          cnt_d = cnt_q + UW'(1);
        end
      end

      S_CRD: begin
        meta_ra = pending_q;
        state_d = S_CCHK;
      end

      S_CCHK: begin
        hit_d      = 1'b0;
        ep_d       = plane_q;
        rem_d      = 3'd1;
        emit_rec_d = 1'b0;
        if (!skip_q && meta_valid && 32'(plane_q) < PLANES &&
            32'(plane_q) < 32'(meta_planes)) begin
          rec_we   = 1'b1;
          rec_wa   = RAW'(pending_q) * RAW'(PLANES) + RAW'(plane_q);
          rec_wd   = rec_in_q;
          status_d = StFree;
        end else begin
          status_d = StSkip;
        end
        if (rlast_q) skip_d = 1'b1;
        state_d = S_RRD;
      end

      S_RRD: begin
        rec_ok_d = rec_ok;
        rec_ra   = rec_ok ? (RAW'(sel_q) * RAW'(PLANES) + RAW'(ep_q)) : '0;
        state_d  = S_EMIT;
      end

      S_EMIT: begin
        // hold the record address so the read data survives an output stall
        rec_ra = rec_ok_q ? (RAW'(sel_q) * RAW'(PLANES) + RAW'(ep_q)) : '0;
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_hit_d    = hit_q;
          out_plane_d  = ep_q;
          out_rec_d    = rec_ok_q ? rec_rd_q : '0;
          out_status_d = status_q;
          out_last_d   = (rem_q == 3'd1);
          if (rem_q == 3'd1) begin
            state_d = S_IDLE;
          end else begin
            ep_d    = ep_q + 2'd1;
            rem_d   = rem_q - 3'd1;
            state_d = S_RRD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      pv_q        <= 1'b0;
      used_q      <= '0;
      pending_q   <= '0;
      skip_q      <= 1'b0;
      cap_q       <= CapW'(CapReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pv_q        <= pv_d;
      used_q      <= used_d;
      pending_q   <= pending_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) cap_q <= cfg_data_i;
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    pidx_q       <= pidx_d;
    op_q         <= op_d;
    key_q        <= key_d;
    plane_q      <= plane_d;
    pc_q         <= pc_d;
    rec_in_q     <= rec_in_d;
    rlast_q      <= rlast_d;
    match_v_q    <= match_v_d;
    match_idx_q  <= match_idx_d;
    match_rank_q <= match_rank_d;
    match_pl_q   <= match_pl_d;
    free_v_q     <= free_v_d;
    free_idx_q   <= free_idx_d;
    lru_v_q      <= lru_v_d;
    lru_idx_q    <= lru_idx_d;
    lru_rank_q   <= lru_rank_d;
    sel_q        <= sel_d;
    rref_q       <= rref_d;
    mode_new_q   <= mode_new_d;
    planes_new_q <= planes_new_d;
    hit_q        <= hit_d;
    status_q     <= status_d;
    ep_q         <= ep_d;
    rem_q        <= rem_d;
    emit_rec_q   <= emit_rec_d;
    rec_ok_q     <= rec_ok_d;
    out_hit_q    <= out_hit_d;
    out_plane_q  <= out_plane_d;
    out_rec_q    <= out_rec_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  // ---------------------------------------------------------------- ports
  assign cfg_ready_o     = 1'b1;
  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign hit_o           = out_hit_q;
  assign out_plane_o     = out_plane_q;
  assign out_size_o      = out_rec_q[SizeW-1:0];
  assign out_alignment_o = out_rec_q[SizeW+AlignW-1:SizeW];
  assign out_type_bits_o = out_rec_q[SizeW+AlignW+TypeW-1:SizeW+AlignW];
  assign out_prefers_o   = out_rec_q[RecW-2];
  assign out_requires_o  = out_rec_q[RecW-1];
  assign store_status_o  = out_status_q;
  assign last_o          = out_last_q;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= ENTRIES)
    else $error("entry count exceeds the number of entries");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while another is in progress");

  a_alloc_not_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == StFree || out_status_q == StEvict)) |-> !out_hit_q)
    else $error("allocating store reported a hit");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_hit_q && out_status_q == StNone) |-> (out_rec_q == '0))
    else $error("miss carried record data");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the keyed LRU result cache core.
`timescale 1ns / 1ps
// Drives requests and capacity writes into the cache and checks every result
// against a behavioral copy of the cache kept here: tags, plane records,
// recency ranks, entry count and the pending store run. Results are queued
// in request order and popped one per accepted output beat. Both channels
// idle at random, apart from one long stretch with no idling at all.
module testbench;
  import lrc_pkg::*;

  localparam int unsigned NumSlots  = 512;
  localparam int unsigned NumPlanes = 3;
  localparam int unsigned CycleLimit = 2_000_000;

  typedef struct {
    logic [63:0] h;
    logic [63:0] m;
    logic [31:0] l;
  } key_t;

  typedef struct {
    logic [1:0]  op;
    key_t        key;
    logic [1:0]  plane;
    logic [1:0]  pcount;
    logic [63:0] size;
    logic [63:0] align;
    logic [31:0] tbits;
    logic        pref;
    logic        reqd;
    logic        rlast;
  } req_t;

  typedef struct {
    logic        hit;
    logic [1:0]  plane;
    logic [63:0] size;
    logic [63:0] align;
    logic [31:0] tbits;
    logic        pref;
    logic        reqd;
    logic [1:0]  status;
    logic        last;
  } res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CapW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t drv = '{op: OpUnused, key: '{h: '0, m: '0, l: '0}, plane: '0, pcount: '0,
                size: '0, align: '0, tbits: '0, pref: 1'b0, reqd: 1'b0, rlast: 1'b0};
  logic out_valid;
  logic out_stall = 1'b0;
  res_t got;

  // no-idle stretch on both sides when set
  bit calm = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  // cache image kept by the testbench
  bit          slot_valid[NumSlots];
  key_t        slot_key[NumSlots];
  int unsigned slot_planes[NumSlots];
  logic [63:0] rec_size[NumSlots][NumPlanes];
  logic [63:0] rec_align[NumSlots][NumPlanes];
  logic [31:0] rec_tbits[NumSlots][NumPlanes];
  logic [1:0]  rec_flags[NumSlots][NumPlanes];
  int unsigned slot_rank[NumSlots];
  int unsigned used_count = 0;
  int unsigned open_slot = 0;
  bit          run_closed = 1'b0;
  logic [CapW-1:0] capacity = CapW'(CapReset);

  res_t pending_results[$];
  key_t known_keys[$];

  initial begin
    forever #6 clk = ~clk;
  end

  lru_keyed_result_cache_core DUT (
    .clk_i                (clk),
    .rst_ni               (rst_n),
    .cfg_valid_i          (cfg_valid),
    .cfg_ready_o          (cfg_ready),
    .cfg_data_i           (cfg_data),
    .in_valid_i           (in_valid),
    .in_stall_o           (in_stall),
    .operation_i          (drv.op),
    .key_high_i           (drv.key.h),
    .key_mid_i            (drv.key.m),
    .key_low_i            (drv.key.l),
    .plane_i              (drv.plane),
    .plane_count_i        (drv.pcount),
    .mem_size_i           (drv.size),
    .mem_alignment_i      (drv.align),
    .type_bits_i          (drv.tbits),
    .prefers_dedicated_i  (drv.pref),
    .requires_dedicated_i (drv.reqd),
    .run_last_i           (drv.rlast),
    .out_valid_o          (out_valid),
    .out_stall_i          (out_stall),
    .hit_o                (got.hit),
    .out_plane_o          (got.plane),
    .out_size_o           (got.size),
    .out_alignment_o      (got.align),
    .out_type_bits_o      (got.tbits),
    .out_prefers_o        (got.pref),
    .out_requires_o       (got.reqd),
    .store_status_o       (got.status),
    .last_o               (got.last)
  );

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic key_t rand_key();
    key_t k;
    k.h = rand64();
    k.m = rand64();
    k.l = $urandom;
    return k;
  endfunction

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int find_slot(key_t k);
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_valid[i] && slot_key[i].h == k.h && slot_key[i].m == k.m &&
          slot_key[i].l == k.l) return i;
    end
    return -1;
  endfunction

  // Move a slot to most recent; younger entries age by one.
  function automatic void promote(int s);
    int unsigned r;
    r = slot_rank[s];
    for (int j = 0; j < NumSlots; j++) begin
      if (slot_valid[j] && j != s && slot_rank[j] < r) slot_rank[j]++;
    end
    slot_rank[s] = 0;
  endfunction

  function automatic res_t cache_record(logic hit, logic [1:0] plane, int s,
                                        logic [1:0] status, logic last);
    res_t r;
    r = '{hit: hit, plane: plane, size: '0, align: '0, tbits: '0, pref: 1'b0,
          reqd: 1'b0, status: status, last: last};
    if (s >= 0 && plane < NumPlanes && plane < slot_planes[s]) begin
      r.size  = rec_size[s][plane];
      r.align = rec_align[s][plane];
      r.tbits = rec_tbits[s][plane];
      r.pref  = rec_flags[s][plane][0];
      r.reqd  = rec_flags[s][plane][1];
    end
    return r;
  endfunction

  function automatic void write_plane(int s, int p, req_t q);
    rec_size[s][p]  = q.size;
    rec_align[s][p] = q.align;
    rec_tbits[s][p] = q.tbits;
    rec_flags[s][p] = {q.reqd, q.pref};
  endfunction

  // Apply one accepted request to the image and queue the results it causes.
  function automatic void cache_apply(req_t q);
    int s;
    int unsigned n, lim, best, pc;
    logic [1:0] status;
    if (q.op == OpLookupAll || q.op == OpLookupPlane) begin
      s = find_slot(q.key);
      if (s < 0) begin
        pending_results.push_back(cache_record(1'b0, 2'd0, -1, StNone, 1'b1));
        return;
      end
      promote(s);
      if (q.op == OpLookupPlane) begin
        pending_results.push_back(cache_record(1'b1, q.plane, s, StNone, 1'b1));
        return;
      end
      n = slot_planes[s];
      if (n < 1) n = 1;
      if (n > NumPlanes) n = NumPlanes;
      for (int p = 0; p < n; p++) begin
        pending_results.push_back(cache_record(1'b1, 2'(p), s, StNone, p + 1 == n));
      end
      return;
    end
    if (q.op == OpUnused) begin
      pending_results.push_back(cache_record(1'b0, 2'd0, -1, StNone, 1'b1));
      return;
    end
    // continuation plane of a store run; the key is not looked at
    if (q.plane != 0) begin
      status = StSkip;
      if (!run_closed && slot_valid[open_slot] && q.plane < NumPlanes &&
          q.plane < slot_planes[open_slot]) begin
        write_plane(open_slot, q.plane, q);
        status = StFree;
      end
      if (q.rlast) run_closed = 1'b1;
      pending_results.push_back(cache_record(1'b0, q.plane, -1, status, 1'b1));
      return;
    end
    // plane 0 of a key already held: skip the whole run
    if (find_slot(q.key) >= 0) begin
      run_closed = 1'b1;
      pending_results.push_back(cache_record(1'b1, 2'd0, -1, StSkip, 1'b1));
      return;
    end
    lim = capacity;
    if (lim < 1) lim = 1;
    if (lim > NumSlots) lim = NumSlots;
    s = -1;
    if (used_count < lim) begin
      for (int i = 0; i < NumSlots; i++) begin
        if (!slot_valid[i]) begin
          s = i;
          break;
        end
      end
    end
    if (s >= 0) begin
      for (int j = 0; j < NumSlots; j++) begin
        if (slot_valid[j]) slot_rank[j]++;
      end
      slot_rank[s] = 0;
      slot_valid[s] = 1'b1;
      used_count++;
      status = StFree;
    end else begin
      // evict the least recent entry
      best = 0;
      for (int i = 0; i < NumSlots; i++) begin
        if (slot_valid[i] && (s < 0 || slot_rank[i] > best)) begin
          s = i;
          best = slot_rank[i];
        end
      end
      if (s < 0) s = 0;
      promote(s);
      slot_valid[s] = 1'b1;
      status = StEvict;
    end
    pc = q.pcount;
    if (pc < 1) pc = 1;
    if (pc > NumPlanes) pc = NumPlanes;
    slot_key[s] = q.key;
    slot_planes[s] = pc;
    for (int p = 1; p < NumPlanes; p++) begin
      rec_size[s][p] = '0;
      rec_align[s][p] = '0;
      rec_tbits[s][p] = '0;
      rec_flags[s][p] = '0;
    end
    write_plane(s, 0, q);
    open_slot = s;
    run_closed = q.rlast;
    pending_results.push_back(cache_record(1'b0, 2'd0, -1, status, 1'b1));
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(string what, logic [63:0] seen, logic [63:0] want);
    $display("MISMATCH @%0t %s: got %h expected %h", $realtime, what, seen, want);
    errors++;
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report("unexpected result, hit", 64'(got.hit), 64'(0));
      end else begin
        want = pending_results.pop_front();
        if (got.hit !== want.hit) report("hit", 64'(got.hit), 64'(want.hit));
        if (got.plane !== want.plane) report("plane", 64'(got.plane), 64'(want.plane));
        if (got.size !== want.size) report("size", got.size, want.size);
        if (got.align !== want.align) report("alignment", got.align, want.align);
        if (got.tbits !== want.tbits) report("type bits", 64'(got.tbits), 64'(want.tbits));
        if (got.pref !== want.pref) report("prefers", 64'(got.pref), 64'(want.pref));
        if (got.reqd !== want.reqd) report("requires", 64'(got.reqd), 64'(want.reqd));
        if (got.status !== want.status) begin
          report("store status", 64'(got.status), 64'(want.status));
        end
        if (got.last !== want.last) report("last", 64'(got.last), 64'(want.last));
      end
    end
  end

  // Stall the result side at random, about 30 percent of the time.
  always @(posedge clk) begin
    out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Send one request; valid stays high after acceptance so back-to-back
  // requests never drop and raise it in the same step.
  task automatic send_req(req_t q);
    int unsigned gap;
    gap = (!calm && $urandom_range(99) < 30) ? $urandom_range(4, 1) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    drv <= q;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    cache_apply(q);
  endtask

  // Hold off until every result is back and the block has settled.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CapW-1:0] value);
    drain();
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    capacity = value;
  endtask

  function automatic req_t make_req(logic [1:0] op, key_t k, logic [1:0] plane,
                                    logic [1:0] pcount, logic rlast);
    req_t q;
    q.op = op;
    q.key = k;
    q.plane = plane;
    q.pcount = pcount;
    q.size = rand64();
    q.align = rand64();
    q.tbits = $urandom;
    q.pref = $urandom_range(1);
    q.reqd = $urandom_range(1);
    q.rlast = rlast;
    return q;
  endfunction

  // Store a whole run for one key; a cut run stops before its final plane.
  task automatic store_run(key_t k, logic [1:0] pcount, bit cut);
    int unsigned n;
    n = (pcount == 0) ? 1 : pcount;
    for (int p = 0; p < n; p++) begin
      if (cut && p == n - 1 && p != 0) break;
      send_req(make_req(OpStore, k, 2'(p), pcount, p == n - 1));
    end
    known_keys.push_back(k);
    if (known_keys.size() > 10) void'(known_keys.pop_front());
  endtask

  function automatic key_t pick_key();
    if (known_keys.size() == 0 || $urandom_range(9) == 0) return rand_key();
    return known_keys[$urandom_range(known_keys.size() - 1)];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    key_t zero_key, ones_key;
    req_t q;
    zero_key = '{h: '0, m: '0, l: '0};
    ones_key = '{h: '1, m: '1, l: '1};
    set_capacity(CapW'(CapReset));
    send_req(make_req(OpLookupAll, zero_key, 2'd0, 2'd1, 1'b0));   // miss on empty
    send_req(make_req(OpUnused, ones_key, 2'd3, 2'd3, 1'b1));      // unused operation
    send_req(make_req(OpStore, ones_key, 2'd1, 2'd3, 1'b0));       // stray continuation
    // all-zero record and all-ones record at key extremes
    q = make_req(OpStore, zero_key, 2'd0, 2'd0, 1'b1);
    q.size = '0; q.align = '0; q.tbits = '0; q.pref = 1'b0; q.reqd = 1'b0;
    send_req(q);
    known_keys.push_back(zero_key);
    q = make_req(OpStore, ones_key, 2'd0, 2'd3, 1'b0);
    q.size = '1; q.align = '1; q.tbits = '1; q.pref = 1'b1; q.reqd = 1'b1;
    send_req(q);
    send_req(make_req(OpStore, zero_key, 2'd1, 2'd0, 1'b0));       // plane 1 lands on open run
    send_req(make_req(OpStore, ones_key, 2'd3, 2'd0, 1'b0));       // plane beyond count
    send_req(make_req(OpStore, ones_key, 2'd2, 2'd0, 1'b1));
    send_req(make_req(OpStore, ones_key, 2'd1, 2'd0, 1'b0));       // after run end
    known_keys.push_back(ones_key);
    send_req(make_req(OpLookupAll, ones_key, 2'd0, 2'd0, 1'b0));
    send_req(make_req(OpLookupAll, zero_key, 2'd0, 2'd0, 1'b0));
    send_req(make_req(OpLookupPlane, ones_key, 2'd1, 2'd0, 1'b0));
    send_req(make_req(OpLookupPlane, zero_key, 2'd2, 2'd0, 1'b0)); // beyond held
    send_req(make_req(OpLookupPlane, ones_key, 2'd3, 2'd0, 1'b0));
    // duplicate key: plane 0 skipped, rest of the run ignored
    send_req(make_req(OpStore, ones_key, 2'd0, 2'd2, 1'b0));
    send_req(make_req(OpStore, ones_key, 2'd1, 2'd2, 1'b1));
    send_req(make_req(OpLookupAll, ones_key, 2'd0, 2'd0, 1'b0));
    // two-plane run with record left unstored on plane 1
    store_run(rand_key(), 2'd2, 1'b1);
    send_req(make_req(OpLookupAll, known_keys[$], 2'd0, 2'd0, 1'b0));
  endtask

  // Tight capacities: zero acts as one, then two entries.
  task automatic test_eviction();
    key_t k0, k1, k2;
    k0 = rand_key();
    k1 = rand_key();
    k2 = rand_key();
    set_capacity('0);
    store_run(k0, 2'd1, 1'b0);
    store_run(k1, 2'd2, 1'b0);
    send_req(make_req(OpLookupAll, k0, 2'd0, 2'd0, 1'b0));
    send_req(make_req(OpLookupAll, k1, 2'd0, 2'd0, 1'b0));
    set_capacity(CapW'(2));
    store_run(k2, 2'd3, 1'b0);
    send_req(make_req(OpLookupPlane, k1, 2'd0, 2'd0, 1'b0));  // k1 becomes most recent
    store_run(k0, 2'd1, 1'b0);
    send_req(make_req(OpLookupAll, k2, 2'd0, 2'd0, 1'b0));
    send_req(make_req(OpLookupAll, k1, 2'd0, 2'd0, 1'b0));
  endtask

  task automatic random_items(int unsigned count);
    int unsigned sent, pick;
    key_t k;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      k = pick_key();
      if (pick < 45) begin
        store_run((known_keys.size() != 0 && $urandom_range(4) == 0) ? k : rand_key(),
                  2'($urandom_range(3)), $urandom_range(9) == 0);
        sent += 2;
      end else if (pick < 85) begin
        send_req(make_req($urandom_range(1) ? OpLookupAll : OpLookupPlane, k,
                          2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1))));
        sent++;
      end else begin
        // noise: unused operation or a stray continuation
        send_req(make_req($urandom_range(1) ? OpUnused : OpStore, rand_key(),
                          2'($urandom_range(3, 1)), 2'($urandom_range(3)),
                          1'($urandom_range(1))));
        sent++;
      end
    end
  endtask

  // Random traffic across the capacity extremes, including a count above limit.
  task automatic test_random();
    set_capacity('1);
    random_items(70);
    calm = 1'b1;
    random_items(40);
    calm = 1'b0;
    set_capacity(CapW'(512));
    random_items(40);
    set_capacity(CapW'(3));   // entries already exceed the new limit
    random_items(70);
    set_capacity(CapW'(1));
    random_items(25);
    set_capacity(CapW'(CapReset));
    random_items(25);
  endtask

  initial begin
    for (int i = 0; i < NumSlots; i++) begin
      slot_valid[i] = 1'b0;
      slot_rank[i] = 0;
      slot_planes[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_eviction();
    test_random();
    drain();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
